// File: sv/ptq_pkg.sv
// Package for the periodic traffic table query block.
// Holds field widths, mode and kind codes, and the stored flow record.
// No dependencies.
`default_nettype none

package ptq_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int NODE_COUNT      = 64;
  localparam int RATE_FRAC_BITS  = 16;

  localparam int NODE_W  = 6;
  localparam int RATE_W  = 17;
  localparam int TIME_W  = 32;
  localparam int CUM_W   = 21;
  localparam int SCNT_W  = 5;

  // A rate above one is stored as exactly one.
  localparam logic [31:0] RATE_ONE = 32'(64'd1 << RATE_FRAC_BITS);

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_t;

  localparam logic KIND_ENTRY   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [RATE_W-1:0] inject;
    logic [RATE_W-1:0] retrans;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_time;
    logic [TIME_W-1:0] period;
  } flow_t;

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
    logic [RATE_W-1:0] res;
    res = r;
    if (32'(r) > RATE_ONE) begin
      res = RATE_ONE[RATE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/ptq_if.sv
// Valid/ready channel interfaces for the traffic table query block.
// Depends on ptq_pkg for field widths.
`default_nettype none

interface ptq_in_if import ptq_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [NODE_W-1:0] src_node;
  logic [NODE_W-1:0] dst_node;
  logic [RATE_W-1:0] inject_rate;
  logic [RATE_W-1:0] retrans_rate;
  logic [TIME_W-1:0] on_time;
  logic [TIME_W-1:0] off_time;
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] cycle;
  logic              use_injection;

  modport source (
    output valid, mode, src_node, dst_node, inject_rate, retrans_rate,
           on_time, off_time, period, cycle, use_injection,
    input  ready
  );
  modport sink (
    input  valid, mode, src_node, dst_node, inject_rate, retrans_rate,
           on_time, off_time, period, cycle, use_injection,
    output ready
  );
endinterface

interface ptq_out_if import ptq_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [NODE_W-1:0] dest_out;
  logic [CUM_W-1:0]  cum_rate;
  logic [SCNT_W-1:0] source_count;
  logic              last;

  modport source (
    output valid, kind, dest_out, cum_rate, source_count, last,
    input  ready
  );
  modport sink (
    input  valid, kind, dest_out, cum_rate, source_count, last,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/ptq_mod_div.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on ptq_pkg for the operand width.
`default_nettype none

module ptq_mod_div import ptq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic                   done,
  output logic [TIME_W-1:0]      remainder
);

  localparam int STEP_W = $clog2(TIME_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] dvd_r;
  logic [TIME_W-1:0] dsr_r;

  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              fits;
  logic [TIME_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[TIME_W-1]};
    fits    = trial >= {1'b0, dsr_r};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        dvd_r  <= {dvd_r[TIME_W-2:0], 1'b0};
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rem_r < dsr_r)
    else $error("remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(start))
    else $error("divider became busy without a start");

endmodule

`default_nettype wire

// File: sv/periodic_traffic_table_query.sv
// Periodic traffic table: clear, append and per-source query of flows.
// Clear and append leave the block idle, so a new item can be accepted the next cycle.
// A query reads and checks each table entry in turn; for each flow of the
// queried source with a nonzero period it runs a bit-serial 32-bit remainder and compare,
// emits an entry beat for each active flow and ends with a summary; output stalls hold it.
// One query at a time. Synchronous reset empties the table; the flow memory is not cleared.
`default_nettype none

module periodic_traffic_table_query import ptq_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ptq_in_if.sink    in_ch,
  ptq_out_if.source out_ch
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CUM_W-1:0] CUM_MAX = '1;
  localparam logic [SCNT_W-1:0] SCNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_CMP,
    ST_EMIT,
    ST_SUM
  } state_t;

  state_t            st_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     idx_r;
  logic [NODE_W-1:0] q_src_r;
  logic [TIME_W-1:0] q_cycle_r;
  logic              q_inj_r;
  logic [CUM_W-1:0]  cum_r;
  logic [SCNT_W-1:0] cnt_r;

  logic              out_valid_r;
  logic              out_kind_r;
  logic [NODE_W-1:0] out_dest_r;
  logic [CUM_W-1:0]  out_cum_r;
  logic [SCNT_W-1:0] out_cnt_r;
  logic              out_last_r;

  flow_t             mem [TABLE_DEPTH];
  flow_t             rd_data_r;
  flow_t             wr_data;
  logic              wr_en;
  logic              rd_en;

  logic              in_beat;
  logic              out_free;
  logic              out_load;
  logic              node_ok;
  logic              div_start;
  logic              div_done;
  logic [TIME_W-1:0] phase;
  logic              active;
  logic [RATE_W-1:0] sel_rate;
  logic [CUM_W:0]    sum;

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  // A new beat goes into the output register this cycle.
  assign out_load    = out_free && ((st_r == ST_EMIT) || (st_r == ST_SUM));

  assign node_ok = (32'(in_ch.src_node) < 32'(NODE_COUNT)) &&
                   (32'(in_ch.dst_node) < 32'(NODE_COUNT));
  assign wr_en   = in_beat && (in_ch.mode == MODE_APPEND) && (count_r < DEPTH_C) && node_ok;
  assign rd_en   = (st_r == ST_READ) && (idx_r != count_r);

  always_comb begin
    wr_data.src      = in_ch.src_node;
    wr_data.dst      = in_ch.dst_node;
    wr_data.inject   = clamp_rate(in_ch.inject_rate);
    wr_data.retrans  = clamp_rate(in_ch.retrans_rate);
    wr_data.on_time  = in_ch.on_time;
    wr_data.off_time = in_ch.off_time;
    wr_data.period   = in_ch.period;
  end

  // Flow memory: one write port for appends, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[AW-1:0]];
    end
  end

  assign div_start = (st_r == ST_CHECK) && (rd_data_r.src == q_src_r) &&
                     (rd_data_r.period != '0);

  ptq_mod_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (q_cycle_r),
    .divisor   (rd_data_r.period),
    .done      (div_done),
    .remainder (phase)
  );

  always_comb begin
    active   = (phase > rd_data_r.on_time) && (phase < rd_data_r.off_time);
    sel_rate = q_inj_r ? rd_data_r.inject : rd_data_r.retrans;
    sum      = {1'b0, cum_r} + (CUM_W + 1)'(sel_rate);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_beat) begin
            unique case (in_ch.mode)
              MODE_CLEAR: begin
                count_r <= '0;
              end
              MODE_APPEND: begin
                if (wr_en) begin
                  count_r <= count_r + 1'b1;
                end
              end
              MODE_QUERY: begin
                q_src_r   <= in_ch.src_node;
                q_cycle_r <= in_ch.cycle;
                q_inj_r   <= in_ch.use_injection;
                idx_r     <= '0;
                cum_r     <= '0;
                cnt_r     <= '0;
                st_r      <= ST_READ;
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          st_r <= (idx_r == count_r) ? ST_SUM : ST_CHECK;
        end
        ST_CHECK: begin
          if (rd_data_r.src != q_src_r) begin
            idx_r <= idx_r + 1'b1;
            st_r  <= ST_READ;
          end else begin
            if (cnt_r != SCNT_MAX) begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (div_start) begin
              st_r <= ST_DIV;
            end else begin
              idx_r <= idx_r + 1'b1;
              st_r  <= ST_READ;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            st_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (active) begin
            cum_r <= sum[CUM_W] ? CUM_MAX : sum[CUM_W-1:0];
            st_r  <= ST_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r  <= ST_READ;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_ENTRY;
            out_dest_r  <= rd_data_r.dst;
            out_cum_r   <= cum_r;
            out_cnt_r   <= '0;
            out_last_r  <= 1'b0;
            idx_r       <= idx_r + 1'b1;
            st_r        <= ST_READ;
          end
        end
        ST_SUM: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= KIND_SUMMARY;
            out_dest_r  <= '0;
            out_cum_r   <= cum_r;
            out_cnt_r   <= cnt_r;
            out_last_r  <= 1'b1;
            st_r        <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.dest_out     = out_dest_r;
  assign out_ch.cum_rate     = out_cum_r;
  assign out_ch.source_count = out_cnt_r;
  assign out_ch.last         = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("flow count beyond table depth");

  a_walk_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CHECK) |-> (idx_r < count_r))
    else $error("query walk past the last flow");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_DIV))
    else $error("remainder arrived while not waiting for it");

endmodule

`default_nettype wire
